### rtl/assert_macros.svh
// Assertion macros of the seat queue RTL, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SPSQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequence holds at every edge where its antecedent holds.
`define SPSQ_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/spsq_pkg.sv
// Shared types and constants of the strict priority seat queue.
package spsq_pkg;

  localparam int LVL_W         = 5;
  localparam int ID_W          = 8;
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int WAIT_W        = 7;
  localparam int TOTAL_W       = 16;
  localparam int MAX_LEVELS    = 16;
  localparam int MAX_SLOTS_DEF = 64;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 40;

  localparam logic [LVL_W-1:0] LEVEL_COUNT_RST = LVL_W'(16);
  localparam logic [CFG_W-1:0] SEAT_LIMIT_RST  = CFG_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEAT_LIMIT  = 1'b1;

  localparam logic REQ_ARRIVE   = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [LVL_W-1:0] level;
    logic [ID_W-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic             apply;
    logic             ins;
    logic [LVL_W-1:0] level;
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] lim;
  } cell_cmd_t;

endpackage

### rtl/strict_priority_seat_queue.sv
// Top level of the strict priority seat queue built on a sorted chain of seats.
//
//   Channel  Dir  Beat contents (lowest bit first)
//   in_      in   tuser: req_type; tdata: requester_id, level
//   out_     out  tdata: accepted, dispatch_valid, served_id, served_level,
//                 waiting_count, total_dispatched
//   cfg_     in   index 0 level_count, index 1 seat_limit
//
// Each item takes its beat in ST_IDLE; in ST_EXEC every seat compares its level and
// the seats from the insertion or removal point on shift by one place at once.
// A result that is not taken holds the block in ST_EXEC.
// No seat needs clearing at reset beyond its valid flag.
`include "assert_macros.svh"

module strict_priority_seat_queue import spsq_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // requester_id, level, zero fill
  input  logic                  in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // accepted, dispatch_valid, served_id,
                                            // served_level, waiting_count,
                                            // total_dispatched, zero fill
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int SW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t               state_r;
  logic [LVL_W-1:0]     level_count_r;
  logic [CFG_W-1:0]     seat_limit_r;
  logic                 req_ins_r;
  logic [ID_W-1:0]      req_id_r;
  logic [LVL_W-1:0]     req_lvl_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [LVL_W-1:0]     eff_levels;
  logic [SW-1:0]        eff_seats;
  logic                 arrive_ok;
  logic                 out_free;
  logic                 finish;
  cell_cmd_t            cmd;

  entry_t               cell_entry [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] cell_keep, cell_skip, cell_head, cell_valid;
  logic [ID_W-1:0]      served_id;
  logic [LVL_W-1:0]     served_level;
  logic                 found;
  logic [SW-1:0]        wait_sw;

  assign eff_levels = (level_count_r > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS)
                                                           : level_count_r;
  assign eff_seats  = (SW'(seat_limit_r) > SW'(MAX_SLOTS)) ? SW'(MAX_SLOTS)
                                                          : SW'(seat_limit_r);
  assign arrive_ok  = (req_lvl_r != '0) && (req_lvl_r <= eff_levels) &&
                      (SW'(count_r) < eff_seats);
  assign out_free   = !out_valid_r || out_tready;
  assign finish     = (state_r == ST_EXEC) && out_free;

  assign cmd = '{apply: finish && (req_ins_r ? arrive_ok : found),
                 ins:   req_ins_r,
                 level: req_lvl_r,
                 id:    req_id_r,
                 lim:   eff_levels};

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_seat
    entry_t prev_e, next_e;
    logic   prev_k, prev_s;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_k = 1'b1;
      assign prev_s = 1'b1;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
      assign prev_k = cell_keep[i-1];
      assign prev_s = cell_skip[i-1];
    end
    if (i == MAX_SLOTS - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_more
      assign next_e = cell_entry[i+1];
    end
    spsq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_entry (prev_e),
      .prev_keep  (prev_k),
      .prev_skip  (prev_s),
      .next_entry (next_e),
      .entry      (cell_entry[i]),
      .keep       (cell_keep[i]),
      .skip       (cell_skip[i]),
      .head       (cell_head[i])
    );
    assign cell_valid[i] = cell_entry[i].valid;
  end

  always_comb begin
    served_id    = '0;
    served_level = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      served_id    = served_id    | (cell_head[i] ? cell_entry[i].id    : '0);
      served_level = served_level | (cell_head[i] ? cell_entry[i].level : '0);
    end
    found = |cell_head;
  end

  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    if (req_ins_r) begin
      if (arrive_ok) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (found) begin
      if (count_r != '0) begin
        count_nxt = count_r - CNT_W'(1);
      end
      if (total_r != '1) begin
        total_nxt = total_r + TOTAL_W'(1);
      end
    end
    wait_sw = SW'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      level_count_r <= LEVEL_COUNT_RST;
      seat_limit_r  <= SEAT_LIMIT_RST;
      count_r       <= '0;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LEVEL_COUNT: level_count_r <= cfg_wdata[LVL_W-1:0];
          CFG_SEAT_LIMIT:  seat_limit_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state_r     <= ST_IDLE;
            count_r     <= count_nxt;
            total_r     <= total_nxt;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      req_ins_r <= (in_tuser == REQ_ARRIVE);
      req_id_r  <= in_tdata[ID_W-1:0];
      req_lvl_r <= in_tdata[ID_W +: LVL_W];
    end
    if (finish) begin
      out_data_r <= {2'b00,
                     total_nxt,
                     wait_sw[WAIT_W-1:0],
                     req_ins_r ? '0 : served_level,
                     req_ins_r ? '0 : served_id,
                     !req_ins_r && found,
                     req_ins_r && arrive_ok};
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SPSQ_ASSERT_ALWAYS(a_seats_packed, $onehot({1'b0, cell_valid} + (MAX_SLOTS + 1)'(1)),
    "occupied seats do not form a prefix of the chain")
  `SPSQ_ASSERT_ALWAYS(a_count_match, $countones(cell_valid) == int'(count_r),
    "waiting count disagrees with occupied seats")
  `SPSQ_ASSERT_IMPLIES(a_one_kind, out_valid_r && out_data_r[0], !out_data_r[1],
    "a beat reports both an arrival and a dispatch")

endmodule

### rtl/spsq_cell.sv
// One seat of the sorted chain: holds an entry and shifts with its neighbors.
module spsq_cell import spsq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  entry_t    prev_entry,
  input  logic      prev_keep,
  input  logic      prev_skip,
  input  entry_t    next_entry,
  output entry_t    entry,
  output logic      keep,
  output logic      skip,
  output logic      head
);

  logic             valid_r, valid_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  entry_t           load;
  logic             take;

  assign entry = '{valid: valid_r, level: level_r, id: id_r};
  assign keep  = valid_r && (level_r >= cmd.level);
  assign skip  = valid_r && (level_r > cmd.lim);
  assign head  = valid_r && !skip && prev_skip;

  always_comb begin
    take = 1'b0;
    load = next_entry;
    if (cmd.apply) begin
      if (cmd.ins) begin
        take = !keep;
        load = prev_keep ? entry_t'{valid: 1'b1, level: cmd.level, id: cmd.id} : prev_entry;
      end else begin
        take = !skip;
        load = next_entry;
      end
    end
    valid_nxt = take ? load.valid : valid_r;
    level_nxt = take ? load.level : level_r;
    id_nxt    = take ? load.id : id_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
    id_r    <= id_nxt;
  end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench of the strict priority seat queue with a per-level FIFO predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spsq_pkg::*;

  typedef struct packed {
    logic             kind;
    logic [ID_W-1:0]  id;
    logic [LVL_W-1:0] lvl;
  } request_t;

  // Listed highest bit first, the fields match the packing of out_tdata.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [WAIT_W-1:0]  waiting;
    logic [LVL_W-1:0]   lvl;
    logic [ID_W-1:0]    id;
    logic               dispatched;
    logic               accepted;
  } outcome_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = REQ_ARRIVE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_LEVEL_COUNT;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  request_t        request_backlog[$];
  outcome_t        pending_outcomes[$];
  request_t        in_flight;
  logic [ID_W-1:0] level_fifo [1:MAX_LEVELS][$];
  int unsigned     seats_taken = 0;
  int unsigned     served_total = 0;
  logic [LVL_W-1:0] level_count_cfg = LEVEL_COUNT_RST;
  logic [CFG_W-1:0] seat_limit_cfg  = SEAT_LIMIT_RST;
  int              queued_count = 0;
  int              sent_count = 0;
  int              mismatch_count = 0;
  int              send_gap = 0;
  int              recv_gap = 0;
  bit              idle_on = 1'b1;

  strict_priority_seat_queue i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned levels_in_use();
    return (level_count_cfg > MAX_LEVELS) ? MAX_LEVELS : level_count_cfg;
  endfunction

  function automatic outcome_t serve_request(request_t req);
    outcome_t    res;
    int unsigned top;
    int unsigned seats;
    res = '0;
    top = levels_in_use();
    seats = (seat_limit_cfg > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : seat_limit_cfg;
    if (req.kind == REQ_ARRIVE) begin
      if (req.lvl >= 1 && req.lvl <= top && seats_taken < seats) begin
        level_fifo[req.lvl].push_back(req.id);
        seats_taken++;
        res.accepted = 1'b1;
      end
    end else begin
      for (int n = top; n >= 1 && !res.dispatched; n--) begin
        if (level_fifo[n].size() > 0) begin
          res.dispatched = 1'b1;
          res.id = level_fifo[n].pop_front();
          res.lvl = LVL_W'(n);
          seats_taken--;
          if (served_total < 16'hFFFF) served_total++;
        end
      end
    end
    res.waiting = WAIT_W'(seats_taken);
    res.total = TOTAL_W'(served_total);
    return res;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_outcomes.push_back(serve_request(in_flight));
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 3);
          in_tvalid <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          in_flight = request_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= in_flight.kind;
          in_tdata <= IN_DATA_W'({in_flight.lvl, in_flight.id});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(outcome_t)-1:0];
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result beat with nothing expected: %0h", out_tdata);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("accepted", want.accepted, got.accepted);
        check_field("dispatch_valid", want.dispatched, got.dispatched);
        check_field("served_id", want.id, got.id);
        check_field("served_level", want.lvl, got.lvl);
        check_field("waiting_count", want.waiting, got.waiting);
        check_field("total_dispatched", want.total, got.total);
      end
    end
    if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= 1'b0;
    end else if (idle_on && rst_n && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic queue_request(logic kind, logic [ID_W-1:0] id, logic [LVL_W-1:0] lvl);
    request_t req;
    req.kind = kind;
    req.id = id;
    req.lvl = lvl;
    request_backlog.push_back(req);
    queued_count++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (sent_count != queued_count || pending_outcomes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LEVEL_COUNT) level_count_cfg = value[LVL_W-1:0];
    else seat_limit_cfg = value;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] levels, logic [CFG_W-1:0] seats, int count,
                           int arrive_pct);
    logic [LVL_W-1:0] lvl;
    wait_drained();
    write_reg(CFG_LEVEL_COUNT, levels);
    write_reg(CFG_SEAT_LIMIT, seats);
    @(negedge clk);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < arrive_pct) begin
        if (levels_in_use() == 0 || $urandom_range(0, 9) == 0)
          lvl = LVL_W'($urandom_range(0, 31));
        else
          lvl = LVL_W'($urandom_range(1, levels_in_use()));
        queue_request(REQ_ARRIVE, ID_W'($urandom_range(0, 255)), lvl);
      end else begin
        queue_request(REQ_DISPATCH, ID_W'($urandom_range(0, 255)),
                      LVL_W'($urandom_range(0, 31)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_request(REQ_DISPATCH, 8'hFF, 5'd31);
    queue_request(REQ_ARRIVE, 8'h00, 5'd0);
    queue_request(REQ_ARRIVE, 8'hFF, 5'd17);
    queue_request(REQ_ARRIVE, 8'h11, 5'd16);
    queue_request(REQ_ARRIVE, 8'h22, 5'd2);
    queue_request(REQ_ARRIVE, 8'h33, 5'd16);
    wait_drained();
    // Entries at level 16 stay hidden while only two levels are in use.
    write_reg(CFG_LEVEL_COUNT, 7'd2);
    @(negedge clk);
    queue_request(REQ_DISPATCH, 8'h00, 5'd0);
    queue_request(REQ_DISPATCH, 8'hA5, 5'd16);
    queue_request(REQ_ARRIVE, 8'h44, 5'd3);
    wait_drained();
    write_reg(CFG_LEVEL_COUNT, 7'd16);
    write_reg(CFG_SEAT_LIMIT, 7'd3);
    @(negedge clk);
    queue_request(REQ_ARRIVE, 8'hFF, 5'd1);
    queue_request(REQ_ARRIVE, 8'h00, 5'd16);
    queue_request(REQ_ARRIVE, 8'h5A, 5'd31);
    queue_request(REQ_DISPATCH, 8'h00, 5'd0);
    queue_request(REQ_DISPATCH, 8'h00, 5'd0);
    queue_request(REQ_DISPATCH, 8'h00, 5'd0);
    queue_request(REQ_DISPATCH, 8'hFF, 5'd31);

    run_phase(7'h7F, 7'h7F, 200, 65);
    run_phase(7'h7F, 7'h7F, 180, 25);
    run_phase(7'd1, 7'd1, 100, 50);
    run_phase(7'd0, 7'd64, 60, 50);
    run_phase(7'h45, 7'd0, 60, 30);
    run_phase(7'd8, 7'd12, 150, 55);
    run_phase(7'd16, 7'd64, 120, 40);
    run_phase(7'd3, 7'h40, 150, 50);
    idle_on = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/spsq_pkg.sv
rtl/spsq_cell.sv
rtl/strict_priority_seat_queue.sv
tb/sv/testbench.sv
